// ===== rtl/core/gprt_pkg.sv =====
// ----------------------------------------------------------------------------
// gprt_pkg
// Shared types, constants and direction helpers of the grid path search.
// ----------------------------------------------------------------------------
package gprt_pkg;

	localparam int WINDOW     = 32;
	localparam int HALF       = WINDOW / 2;
	localparam int CW         = $clog2(WINDOW);
	localparam int AW         = 2 * CW;
	localparam int DEPTH      = WINDOW * WINDOW;
	localparam int RESULT_CAP = 64;
	localparam int EW         = $clog2(RESULT_CAP);
	localparam int NW         = EW + 1;

	localparam logic [7:0] PATH_LIMIT = 8'd64;

	localparam logic [2:0] ST_STEP    = 3'd0;
	localparam logic [2:0] ST_RANGE   = 3'd1;
	localparam logic [2:0] ST_UNREACH = 3'd2;
	localparam logic [2:0] ST_TRACE   = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	localparam logic [3:0] DIR_FIRST  = 4'd1;
	localparam logic [3:0] DIR_CENTER = 4'd5;
	localparam logic [3:0] DIR_LAST   = 4'd9;
	localparam logic [3:0] DIR_SUM    = 4'd10;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic       op;
		logic [4:0] cell_row;
		logic [4:0] cell_col;
		logic       cell_passable;
		logic [7:0] player_x;
		logic [7:0] player_y;
		logic [7:0] target_x;
		logic [7:0] target_y;
	} item_t;

	typedef struct packed {
		logic [3:0] step_dir;
		logic [2:0] status;
		logic       last;
	} res_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_LATCH,
		DP_WIN,
		DP_FILL,
		DP_SEED_P,
		DP_SEED_T,
		DP_SWEEP_INIT,
		DP_NEXT_ROW,
		DP_CELL_RD,
		DP_CELL_SKIP,
		DP_CELL_TAKE,
		DP_NB_RD,
		DP_NB_WR,
		DP_T_RD,
		DP_TR_INIT,
		DP_TR_START,
		DP_TR_RD,
		DP_TR_NEXT,
		DP_TR_TAKE,
		DP_EM_OUT,
		DP_SINGLE
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic in_range;
		logic row_done;
		logic col_done;
		logic cell_skip;
		logic k_last;
		logic changed;
		logic t_found;
		logic at_player;
		logic n_zero;
		logic tr_match;
		logic tr_full;
		logic em_last;
	} dp_stat_t;

	function automatic logic signed [1:0] step_dx(input logic [3:0] k);
		logic signed [1:0] v;
		case (k) inside
			4'd1, 4'd4, 4'd7: v = -2'sd1;
			4'd3, 4'd6, 4'd9: v = 2'sd1;
			default:          v = 2'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [1:0] step_dy(input logic [3:0] k);
		logic signed [1:0] v;
		case (k) inside
			4'd1, 4'd2, 4'd3: v = 2'sd1;
			4'd7, 4'd8, 4'd9: v = -2'sd1;
			default:          v = 2'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/gprt_dp.sv =====
// ----------------------------------------------------------------------------
// gprt_dp
// Datapath: window math, map and distance memories, sweep and trace registers.
// ----------------------------------------------------------------------------
module gprt_dp import gprt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	input  logic     cfg_we,
	input  logic     cfg_index,
	input  logic [7:0] cfg_data,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     res_valid,
	output res_t     res
);

	logic [7:0] width_q, height_q;
	logic [7:0] px_q, py_q, tx_q, ty_q;
	logic signed [9:0] wid_q, hgt_q;
	logic [CW-1:0] pr_q, pc_q, tr_q, tc_q;
	logic in_range_q;

	logic pass_mem [DEPTH];
	logic [7:0] grid_mem [DEPTH];
	logic [3:0] dir_mem [RESULT_CAP];

	logic [AW-1:0] idx_q, fill_addr_s1;
	logic fill_s1, pass_rd_s1;
	logic [7:0] rd_q;
	logic [3:0] dir_rd_q;

	logic [CW-1:0] r_q, c_q, cur_r_q, cur_c_q, tnb_r_q, tnb_c_q;
	logic [3:0] k_q;
	logic [7:0] ctr_q, g_q;
	logic [AW-1:0] nb_addr_q;
	logic changed_q, oob_q;
	logic [NW-1:0] n_q;
	logic [EW-1:0] e_q;
	logic res_valid_q;
	res_t res_q;

	logic [7:0] ox, oy;
	logic [8:0] ex, ey, sx, sy;
	logic [CW-1:0] brow, bcol;
	logic [CW:0] nbr, nbc;
	logic signed [1:0] dx, dy;
	logic [7:0] d;
	logic nb_lower;
	logic [7:0] fill_val;
	logic gwe;
	logic [AW-1:0] gwa, gra;
	logic [7:0] gwd;
	logic [3:0] k_inc;

	// window bounds
	always_comb begin
		ox = (px_q >= 8'(HALF)) ? px_q - 8'(HALF) : 8'd0;
		oy = (py_q >= 8'(HALF)) ? py_q - 8'(HALF) : 8'd0;
		sx = {1'b0, px_q} + 9'(HALF - 1);
		sy = {1'b0, py_q} + 9'(HALF - 1);
		ex = (sx > {1'b0, width_q}) ? {1'b0, width_q} : sx;
		ey = (sy > {1'b0, height_q}) ? {1'b0, height_q} : sy;
	end

	// neighbour address
	always_comb begin
		brow = (cmd.op == DP_TR_RD) ? cur_r_q : r_q;
		bcol = (cmd.op == DP_TR_RD) ? cur_c_q : c_q;
		dx = step_dx(k_q);
		dy = step_dy(k_q);
		nbr = {1'b0, brow} + {{(CW - 1){dy[1]}}, dy};
		nbc = {1'b0, bcol} + {{(CW - 1){dx[1]}}, dx};
		d = ctr_q + 8'd1;
		nb_lower = (rd_q != 8'd0) && (rd_q > d);
		k_inc = (k_q == DIR_CENTER - 4'd1) ? k_q + 4'd2 : k_q + 4'd1;
	end

	always_comb begin
		fill_val = 8'd0;
		if (pass_rd_s1
			&& ($signed({5'd0, fill_addr_s1[AW-1:CW]}) < hgt_q)
			&& ($signed({5'd0, fill_addr_s1[CW-1:0]}) < wid_q)) begin
			fill_val = PATH_LIMIT;
		end
	end

	// distance memory ports
	always_comb begin
		gwe = 1'b0;
		gwa = fill_addr_s1;
		gwd = fill_val;
		if (fill_s1) begin
			gwe = 1'b1;
		end
		case (cmd.op)
			DP_SEED_P: begin
				gwe = 1'b1;
				gwa = {pr_q, pc_q};
				gwd = 8'd1;
			end
			DP_SEED_T: begin
				gwe = 1'b1;
				gwa = {tr_q, tc_q};
				gwd = PATH_LIMIT;
			end
			DP_NB_WR: begin
				gwe = nb_lower;
				gwa = nb_addr_q;
				gwd = d;
			end
			default: ;
		endcase
		case (cmd.op)
			DP_NB_RD, DP_TR_RD: gra = {nbr[CW-1:0], nbc[CW-1:0]};
			DP_T_RD:            gra = {tr_q, tc_q};
			default:            gra = {r_q, c_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD) begin
			pass_mem[{item.cell_row, item.cell_col}] <= item.cell_passable;
		end
		pass_rd_s1 <= pass_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (gwe) begin
			grid_mem[gwa] <= gwd;
		end
		rd_q <= grid_mem[gra];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_TR_TAKE) begin
			dir_mem[n_q[EW-1:0]] <= DIR_SUM - k_q;
		end
		dir_rd_q <= dir_mem[e_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 8'd198;
			height_q    <= 8'd66;
			fill_s1     <= 1'b0;
			changed_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default:    ;
				endcase
			end
			fill_s1 <= (cmd.op == DP_FILL);
			if (cmd.op == DP_SEED_T || cmd.op == DP_SWEEP_INIT) begin
				changed_q <= 1'b0;
			end else if (cmd.op == DP_NB_WR && nb_lower) begin
				changed_q <= 1'b1;
			end
			res_valid_q <= (cmd.op == DP_EM_OUT) || (cmd.op == DP_SINGLE);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		fill_addr_s1 <= idx_q;
		case (cmd.op)
			DP_LATCH: begin
				px_q <= item.player_x;
				py_q <= item.player_y;
				tx_q <= item.target_x;
				ty_q <= item.target_y;
			end
			DP_WIN: begin
				wid_q      <= $signed({1'b0, ex}) - $signed({2'b0, ox});
				hgt_q      <= $signed({1'b0, ey}) - $signed({2'b0, oy});
				pr_q       <= CW'(py_q - oy);
				pc_q       <= CW'(px_q - ox);
				tr_q       <= CW'(ty_q - oy);
				tc_q       <= CW'(tx_q - ox);
				in_range_q <= (tx_q >= ox) && ({1'b0, tx_q} < ex)
					&& (ty_q >= oy) && ({1'b0, ty_q} < ey);
				idx_q      <= '0;
			end
			DP_FILL: idx_q <= idx_q + AW'(1);
			DP_SEED_T, DP_SWEEP_INIT: begin
				r_q <= CW'(1);
				c_q <= CW'(1);
			end
			DP_NEXT_ROW: begin
				r_q <= r_q + CW'(1);
				c_q <= CW'(1);
			end
			DP_CELL_SKIP: c_q <= c_q + CW'(1);
			DP_CELL_TAKE: begin
				ctr_q <= rd_q;
				k_q   <= DIR_FIRST;
			end
			DP_NB_RD: nb_addr_q <= {nbr[CW-1:0], nbc[CW-1:0]};
			DP_NB_WR: begin
				k_q <= k_inc;
				if (k_q == DIR_LAST) begin
					c_q <= c_q + CW'(1);
				end
			end
			DP_TR_INIT: begin
				cur_r_q <= tr_q;
				cur_c_q <= tc_q;
				g_q     <= rd_q;
				n_q     <= '0;
				e_q     <= '0;
			end
			DP_TR_START: k_q <= DIR_FIRST;
			DP_TR_RD: begin
				tnb_r_q <= nbr[CW-1:0];
				tnb_c_q <= nbc[CW-1:0];
				oob_q   <= nbr[CW] | nbc[CW];
			end
			DP_TR_NEXT: k_q <= k_q + 4'd1;
			DP_TR_TAKE: begin
				cur_r_q <= tnb_r_q;
				cur_c_q <= tnb_c_q;
				g_q     <= rd_q;
				n_q     <= n_q + NW'(1);
			end
			DP_EM_OUT: begin
				res_q <= '{step_dir: dir_rd_q, status: ST_STEP, last: stat.em_last};
				e_q   <= e_q + EW'(1);
			end
			DP_SINGLE: res_q <= '{step_dir: 4'd0, status: cmd.code, last: 1'b1};
			default: ;
		endcase
	end

	always_comb begin
		stat.fill_last = (idx_q == AW'(DEPTH - 1));
		stat.in_range  = in_range_q;
		stat.row_done  = ($signed(10'({5'd0, r_q}) + 10'd2) > hgt_q);
		stat.col_done  = ($signed(10'({5'd0, c_q}) + 10'd2) > wid_q);
		stat.cell_skip = (rd_q == 8'd0) || (rd_q >= PATH_LIMIT - 8'd1);
		stat.k_last    = (k_q == DIR_LAST);
		stat.changed   = changed_q;
		stat.t_found   = (rd_q < PATH_LIMIT);
		stat.at_player = (cur_r_q == pr_q) && (cur_c_q == pc_q);
		stat.n_zero    = (n_q == '0);
		stat.tr_match  = !oob_q && (g_q >= 8'd2) && (rd_q == g_q - 8'd1);
		stat.tr_full   = (n_q >= NW'(RESULT_CAP));
		stat.em_last   = ({1'b0, e_q} + NW'(1) == n_q);
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/gprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// gprt_ctrl
// Controller: sequences window setup, fill, relaxation sweeps, trace, output.
// ----------------------------------------------------------------------------
module gprt_ctrl import gprt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     search,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_WIN,
		S_FILL,
		S_FILL_END,
		S_SEED_P,
		S_SEED_T,
		S_CELL,
		S_CELL_CHK,
		S_NB_RD,
		S_NB_WR,
		S_T_CHK,
		S_TR_LOOP,
		S_TR_RD,
		S_TR_CMP,
		S_EM_RD,
		S_EM_OUT,
		S_SINGLE
	} state_t;

	state_t state_q, state_d;
	logic [2:0] code_q, code_d;

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '{op: DP_NOP, code: code_q};
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (search) begin
						cmd.op  = DP_LATCH;
						state_d = S_WIN;
					end else begin
						cmd.op = DP_LOAD;
					end
				end
			end
			S_WIN: begin
				cmd.op  = DP_WIN;
				state_d = S_FILL;
			end
			S_FILL: begin
				cmd.op = DP_FILL;
				if (stat.fill_last) begin
					state_d = S_FILL_END;
				end
			end
			S_FILL_END: state_d = S_SEED_P;
			S_SEED_P: begin
				cmd.op = DP_SEED_P;
				if (stat.in_range) begin
					state_d = S_SEED_T;
				end else begin
					code_d  = ST_RANGE;
					state_d = S_SINGLE;
				end
			end
			S_SEED_T: begin
				cmd.op  = DP_SEED_T;
				state_d = S_CELL;
			end
			S_CELL: begin
				if (stat.row_done) begin
					cmd.op  = DP_T_RD;
					state_d = S_T_CHK;
				end else if (stat.col_done) begin
					cmd.op = DP_NEXT_ROW;
				end else begin
					cmd.op  = DP_CELL_RD;
					state_d = S_CELL_CHK;
				end
			end
			S_CELL_CHK: begin
				if (stat.cell_skip) begin
					cmd.op  = DP_CELL_SKIP;
					state_d = S_CELL;
				end else begin
					cmd.op  = DP_CELL_TAKE;
					state_d = S_NB_RD;
				end
			end
			S_NB_RD: begin
				cmd.op  = DP_NB_RD;
				state_d = S_NB_WR;
			end
			S_NB_WR: begin
				cmd.op  = DP_NB_WR;
				state_d = stat.k_last ? S_CELL : S_NB_RD;
			end
			S_T_CHK: begin
				if (stat.t_found) begin
					cmd.op  = DP_TR_INIT;
					state_d = S_TR_LOOP;
				end else if (stat.changed) begin
					cmd.op  = DP_SWEEP_INIT;
					state_d = S_CELL;
				end else begin
					code_d  = ST_UNREACH;
					state_d = S_SINGLE;
				end
			end
			S_TR_LOOP: begin
				if (stat.at_player) begin
					if (stat.n_zero) begin
						code_d  = ST_EMPTY;
						state_d = S_SINGLE;
					end else begin
						state_d = S_EM_RD;
					end
				end else begin
					cmd.op  = DP_TR_START;
					state_d = S_TR_RD;
				end
			end
			S_TR_RD: begin
				cmd.op  = DP_TR_RD;
				state_d = S_TR_CMP;
			end
			S_TR_CMP: begin
				if (stat.tr_match) begin
					if (stat.tr_full) begin
						code_d  = ST_TRACE;
						state_d = S_SINGLE;
					end else begin
						cmd.op  = DP_TR_TAKE;
						state_d = S_TR_LOOP;
					end
				end else if (stat.k_last) begin
					code_d  = ST_TRACE;
					state_d = S_SINGLE;
				end else begin
					cmd.op  = DP_TR_NEXT;
					state_d = S_TR_RD;
				end
			end
			S_EM_RD: state_d = S_EM_OUT;
			S_EM_OUT: begin
				cmd.op  = DP_EM_OUT;
				state_d = stat.em_last ? S_IDLE : S_EM_RD;
			end
			S_SINGLE: begin
				cmd.op  = DP_SINGLE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_STEP;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			busy    <= (state_d != S_IDLE);
		end
	end

endmodule

// ===== rtl/core/grid_path_relax_and_trace.sv =====
// ----------------------------------------------------------------------------
// grid_path_relax_and_trace
// A load item is taken while idle, loads back to back, with no result. A search
// sets up the window, fills the distance memory and seeds player and target, then
// sweeps the interior cells, relaxing the neighbours of each live cell, and traces
// the path back from the target into step results; one search at a time.
// Results are single-cycle strobes that the receiver cannot stall.
// Reset: dungeon size 198 x 66, controller idle; the map is undefined until loaded.
// ----------------------------------------------------------------------------
module grid_path_relax_and_trace import gprt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output logic       res_valid,
	output res_t       res
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy_int;

	assign cfg_ready = 1'b1;
	assign busy      = busy_int;

	gprt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start & ~busy_int),
		.search (item.op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy_int)
	);

	gprt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

// ===== rtl/core/gprt_check.sv =====
// ----------------------------------------------------------------------------
// gprt_check
// Port-level checks of the grid path search, bound to the top level.
// ----------------------------------------------------------------------------
module gprt_check import gprt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input item_t      item,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       cfg_index,
	input logic [7:0] cfg_data,
	input logic       res_valid,
	input res_t       res
);

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.op) |=> !busy)
		else $error("load transfer made the block busy");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op) |=> busy)
		else $error("search transfer did not raise busy");

	a_single_form: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ST_STEP) |-> (res.last && res.step_dir == 4'd0))
		else $error("non-step result not a lone final result");

	a_step_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_STEP) |->
		(res.step_dir >= 4'd1 && res.step_dir <= 4'd9 && res.step_dir != DIR_CENTER))
		else $error("bad step direction");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last) |=> !res_valid)
		else $error("result after final result");

endmodule

bind grid_path_relax_and_trace gprt_check u_check (.*);

// ===== tb/gprt_path_monitor.sv =====
// ----------------------------------------------------------------------------
// gprt_path_monitor
// Watches the item, config and result channels of the grid path search,
// predicts the step sequence of every accepted search and compares each
// result transfer, field by field, against the oldest predicted step.
// ----------------------------------------------------------------------------
module gprt_path_monitor import gprt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  item_t      item,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       res_valid,
	input  res_t       res,
	output int         errors,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MOVE_DX [10] = '{0, -1, 0, 1, -1, 0, 1, -1, 0, 1};
	localparam int MOVE_DY [10] = '{0, 1, 1, 1, 0, 0, 0, -1, -1, -1};

	logic [7:0] map_width;
	logic [7:0] map_height;
	logic       open_cell [DEPTH];
	int         dist_grid [DEPTH];
	res_t       step_queue [$];

	assign pending = step_queue.size();

	function automatic int dist_at(int r, int c);
		if (r < 0 || c < 0 || r >= WINDOW || c >= WINDOW)
			return 0;
		return dist_grid[r * WINDOW + c];
	endfunction

	function automatic void push_single(logic [2:0] st);
		res_t rr;
		rr.step_dir = '0;
		rr.status   = st;
		rr.last     = 1'b1;
		step_queue.push_back(rr);
	endfunction

	function automatic void plan_route(item_t it);
		int ox, oy, ex, ey, wid, hgt, pr, pc, tr, tc;
		int r, c, t, d, nb, want, sel, n;
		bit changed, hit;
		logic [3:0] steps [RESULT_CAP];
		res_t rr;
		ox = int'(it.player_x) - HALF;
		if (ox < 0) ox = 0;
		oy = int'(it.player_y) - HALF;
		if (oy < 0) oy = 0;
		ex = int'(it.player_x) + HALF - 1;
		if (ex > int'(map_width)) ex = int'(map_width);
		ey = int'(it.player_y) + HALF - 1;
		if (ey > int'(map_height)) ey = int'(map_height);
		wid = ex - ox;
		hgt = ey - oy;
		for (int i = 0; i < DEPTH; i++)
			dist_grid[i] = 0;
		for (r = 0; r < hgt; r++)
			for (c = 0; c < wid; c++)
				if (open_cell[r * WINDOW + c])
					dist_grid[r * WINDOW + c] = int'(PATH_LIMIT);
		pr = int'(it.player_y) - oy;
		pc = int'(it.player_x) - ox;
		dist_grid[pr * WINDOW + pc] = 1;
		if (!(int'(it.target_x) >= ox && int'(it.target_x) < ex &&
		      int'(it.target_y) >= oy && int'(it.target_y) < ey)) begin
			push_single(ST_RANGE);
			return;
		end
		tr = int'(it.target_y) - oy;
		tc = int'(it.target_x) - ox;
		dist_grid[tr * WINDOW + tc] = int'(PATH_LIMIT);
		do begin
			changed = 0;
			for (r = 1; r < hgt - 1; r++)
				for (c = 1; c < wid - 1; c++) begin
					t = dist_grid[r * WINDOW + c];
					d = t + 1;
					if (t != 0 && d < int'(PATH_LIMIT))
						for (int k = 1; k < 10; k++)
							if (k != 5) begin
								nb = (r + MOVE_DY[k]) * WINDOW + (c + MOVE_DX[k]);
								if (dist_grid[nb] != 0 && dist_grid[nb] > d) begin
									dist_grid[nb] = d;
									changed  = 1;
								end
							end
				end
			if (dist_grid[tr * WINDOW + tc] < int'(PATH_LIMIT))
				changed = 0;
		end while (changed);
		if (dist_grid[tr * WINDOW + tc] >= int'(PATH_LIMIT)) begin
			push_single(ST_UNREACH);
			return;
		end
		n = 0;
		r = tr;
		c = tc;
		while (r != pr || c != pc) begin
			want = dist_at(r, c) - 1;
			hit  = 0;
			sel  = 0;
			for (int k = 1; k < 10; k++)
				if (!hit && want != 0 && dist_at(r + MOVE_DY[k], c + MOVE_DX[k]) == want) begin
					hit = 1;
					sel = k;
				end
			if (!hit || sel == int'(DIR_CENTER) || n >= RESULT_CAP) begin
				push_single(ST_TRACE);
				return;
			end
			steps[n] = 4'(int'(DIR_SUM) - sel);
			n++;
			r += MOVE_DY[sel];
			c += MOVE_DX[sel];
		end
		if (n == 0) begin
			push_single(ST_EMPTY);
			return;
		end
		for (int k = 0; k < n; k++) begin
			rr.step_dir = steps[k];
			rr.status   = ST_STEP;
			rr.last     = (k == n - 1);
			step_queue.push_back(rr);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want_res;
		int   bad;
		if (!arst_n) begin
			map_width  <= 8'd198;
			map_height <= 8'd66;
			errors     <= 0;
			step_queue.delete();
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH)
					map_width <= cfg_data;
				else
					map_height <= cfg_data;
			end
			if (start && !busy) begin
				if (!item.op)
					open_cell[item.cell_row * WINDOW + item.cell_col] = item.cell_passable;
				else
					plan_route(item);
			end
			if (res_valid) begin
				if (step_queue.size() == 0) begin
					$error("unexpected result transfer %p", res);
					bad++;
				end else begin
					want_res = step_queue.pop_front();
					if (res.step_dir !== want_res.step_dir) begin
						$error("step_dir expected %0d got %0d", want_res.step_dir, res.step_dir);
						bad++;
					end
					if (res.status !== want_res.status) begin
						$error("status expected %0d got %0d", want_res.status, res.status);
						bad++;
					end
					if (res.last !== want_res.last) begin
						$error("last expected %0d got %0d", want_res.last, res.last);
						bad++;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end

endmodule

// ===== tb/tb_grid_path_relax_and_trace.sv =====
// ----------------------------------------------------------------------------
// tb_grid_path_relax_and_trace
// Loads the map corner used by small dungeon sizes, then runs directed and
// random load and search items over several dungeon sizes with random gaps
// on the item channel; the path monitor predicts and checks every result transfer.
// ----------------------------------------------------------------------------
module tb_grid_path_relax_and_trace;
	import gprt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 40_000_000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	item_t      item;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       res_valid;
	res_t       res;
	int         errors;
	int         pending;
	longint     cycles;
	int         load_count;
	int         search_count;
	int         size_count;
	int         cur_width;

	grid_path_relax_and_trace uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .res_valid(res_valid), .res(res)
	);

	gprt_path_monitor u_path_mon (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .res_valid(res_valid), .res(res),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [7:0] clamp8(int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return 8'(v);
	endfunction

	task automatic send(item_t it);
		@(negedge clk);
		while (busy) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		item  = it;
		if (it.op) search_count++;
		else load_count++;
	endtask

	task automatic idle_gap(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_size(logic [7:0] w, logic [7:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cur_width = w;
		size_count++;
	endtask

	task automatic load_cell(int r, int c, logic p);
		item_t it;
		it = $urandom();
		it.op            = 1'b0;
		it.cell_row      = 5'(r);
		it.cell_col      = 5'(c);
		it.cell_passable = p;
		send(it);
	endtask

	task automatic search(int px, int py, int tx, int ty);
		item_t it;
		it = $urandom();
		it.op       = 1'b1;
		it.player_x = clamp8(px);
		it.player_y = clamp8(py);
		it.target_x = clamp8(tx);
		it.target_y = clamp8(ty);
		send(it);
	endtask

	task automatic random_item();
		int px, py;
		if ($urandom_range(0, 9) < 6) begin
			load_cell($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 3) != 0);
		end else if ($urandom_range(0, 4) == 0) begin
			search($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
		end else begin
			px = $urandom_range(0, (cur_width > 40 ? 40 : cur_width + 2));
			py = $urandom_range(0, 20);
			search(px, py, px + $urandom_range(0, 12) - 6, py + $urandom_range(0, 12) - 6);
		end
	endtask

	initial begin
		int gap;
		cycles       = 0;
		load_count   = 0;
		search_count = 0;
		size_count   = 0;
		cur_width    = 198;
		start        = 1'b0;
		item         = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_WIDTH;
		cfg_data     = '0;
		arst_n       = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// dungeon sizes stay within 8 x 8, so this corner is all a search reads
		set_size(8'd8, 8'd8);
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++)
				load_cell(r, c, $urandom_range(0, 3) != 0);

		// directed
		search(3, 3, 5, 6);
		search(3, 3, 255, 3);
		set_size(8'd1, 8'd1);
		search(0, 0, 0, 0);
		search(5, 5, 0, 0);
		set_size(8'd8, 8'd8);
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				load_cell(3 + dr, 3 + dc, 1'b1);
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				if (dr != 0 || dc != 0)
					search(3, 3, 3 + dc, 3 + dr);
		search(1, 1, 6, 6);

		// random
		for (int i = 0; i < 20; i++) begin
			if (i % 5 == 0) begin
				case ($urandom_range(0, 3))
					0:       set_size(8'd8, 8'($urandom_range(1, 8)));
					1:       set_size(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
					default: set_size(8'($urandom_range(4, 8)), 8'($urandom_range(4, 8)));
				endcase
			end
			if (i == 10)
				wait_idle();
			random_item();
			if ($urandom_range(0, 7) == 0) gap = $urandom_range(10, 40);
			else if ($urandom_range(0, 1) == 0) gap = 0;
			else gap = $urandom_range(1, 3);
			idle_gap(gap);
		end

		wait_idle();
		repeat (100) @(negedge clk);
		$display("covered %0d cell loads and %0d searches over %0d dungeon sizes",
			load_count, search_count, size_count);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/gprt_pkg.sv
rtl/core/gprt_dp.sv
rtl/core/gprt_ctrl.sv
rtl/core/grid_path_relax_and_trace.sv
rtl/core/gprt_check.sv
tb/gprt_path_monitor.sv
tb/tb_grid_path_relax_and_trace.sv
